>>> rtl/bptb_pkg.sv
// shared constants, types and state codes for the bezier bounding box unit
package bptb_pkg;

  localparam int CB     = 32;   // coordinate width
  localparam int TBITS  = 30;   // curve parameter fraction bits
  localparam int EPS_W  = 16;   // epsilon register width
  localparam int OP_W   = 2;
  localparam int CF_W   = 36;   // raw coefficient width
  localparam int SC_W   = 31;   // scaled coefficient width
  localparam int RN_W   = 34;   // root numerator / denominator width
  localparam int DW     = 31;   // divider operand and quotient width
  localparam int MA_W   = 34;   // multiplier operand a
  localparam int MB_W   = 30;   // multiplier operand b
  localparam int SQ_W   = 64;   // square root radicand width
  localparam int ST_W   = 15;

  typedef logic signed [CB-1:0]   coord_t;
  typedef logic signed [CF_W-1:0] coef_t;
  typedef logic signed [SC_W-1:0] scoef_t;
  typedef logic signed [RN_W-1:0] rnum_t;
  typedef logic [TBITS-1:0]       tpar_t;

  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam tpar_t  TMAX = {TBITS{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_MOVE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_QUAD  = 2'd2,
    OP_CUBIC = 2'd3
  } op_t;

  // de casteljau scripts over a 4-entry shift line, bit k: 1 lerp, 0 drop
  localparam logic [8:0] SCR_CUBIC = 9'b100110111;
  localparam logic [8:0] SCR_QUAD  = 9'b000010011;
  localparam logic [3:0] LEN_CUBIC = 4'd9;
  localparam logic [3:0] LEN_QUAD  = 4'd5;

  typedef enum logic [ST_W-1:0] {
    ST_IDLE = 15'b000000000000001,
    ST_ENDS = 15'b000000000000010,
    ST_COEF = 15'b000000000000100,
    ST_CHK  = 15'b000000000001000,
    ST_SQ1  = 15'b000000000010000,
    ST_SQ2  = 15'b000000000100000,
    ST_DISC = 15'b000000001000000,
    ST_SQRT = 15'b000000010000000,
    ST_RSET = 15'b000000100000000,
    ST_ROOT = 15'b000001000000000,
    ST_DIV  = 15'b000010000000000,
    ST_EVM  = 15'b000100000000000,
    ST_EVA  = 15'b001000000000000,
    ST_GROW = 15'b010000000000000,
    ST_DONE = 15'b100000000000000
  } state_t;

endpackage

>>> rtl/bptb_in_if.sv
// request channel carrying one path verb and its points
interface bptb_in_if;
  import bptb_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic             start_path;
  logic signed [CB-1:0] pa_x;
  logic signed [CB-1:0] pa_y;
  logic signed [CB-1:0] pb_x;
  logic signed [CB-1:0] pb_y;
  logic signed [CB-1:0] pc_x;
  logic signed [CB-1:0] pc_y;
  modport source (output valid, op, start_path, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y,
                  input ready);
  modport sink   (input valid, op, start_path, pa_x, pa_y, pb_x, pb_y, pc_x, pc_y,
                  output ready);
endinterface

>>> rtl/bptb_out_if.sv
// result channel carrying the running box
interface bptb_out_if;
  import bptb_pkg::*;
  logic valid;
  logic ready;
  logic signed [CB-1:0] box_min_x;
  logic signed [CB-1:0] box_min_y;
  logic signed [CB-1:0] box_max_x;
  logic signed [CB-1:0] box_max_y;
  modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

>>> rtl/bptb_mul.sv
// shared unsigned multiplier with registered product
module bptb_mul #(
  parameter int AW = bptb_pkg::MA_W,
  parameter int BW = bptb_pkg::MB_W
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  logic [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

  assign p = p_r;
endmodule

>>> rtl/bptb_div.sv
// restoring fraction divider, quotient = floor(num * 2^(W-1) / den), one bit a cycle
module bptb_div #(
  parameter int W = bptb_pkg::DW
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W);

  logic [W+1:0]  rem_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          ge;
  logic [W+1:0]  rem_sub;

  // num <= den on entry so the remainder stays below twice den
  assign ge      = rem_r >= {2'b00, den_r};
  assign rem_sub = ge ? (rem_r - {2'b00, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(W-1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num};
      den_r <= den;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[W:0], 1'b0};
      q_r   <= {q_r[W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
endmodule

>>> rtl/bptb_sqrt.sv
// digit-by-digit integer square root, two radicand bits a cycle
module bptb_sqrt #(
  parameter int W = bptb_pkg::SQ_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   din,
  output logic           busy,
  output logic           done,
  output logic [W/2-1:0] root
);
  logic [W-1:0] v_r;
  logic [W-1:0] res_r;
  logic [W-1:0] bit_r;
  logic         busy_r;
  logic         done_r;
  logic [W-1:0] sum;
  logic         ge;

  assign sum = res_r + bit_r;
  assign ge  = v_r >= sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= din;
      res_r <= '0;
      bit_r <= {2'b01, {(W-2){1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        v_r   <= v_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = res_r[W/2-1:0];
endmodule

>>> rtl/bezier_path_tight_bounds_unit.sv
// top level: tight bounding box of a bezier path, one verb per request
// a move or line only records its end points; a quadratic or cubic also runs the shared
//   31-step divider per root and, for a cubic, the shared 32-step square root per axis,
//   plus lerps (ST_EVM then ST_EVA) on the one shared multiplier
// throughput: one request at a time; the next request is taken once the result is
//   delivered or taken in the same cycle
// reset (synchronous, active low): box cleared to empty, current point at origin,
//   epsilon zero; no clearing pass
module bezier_path_tight_bounds_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  bptb_in_if.sink                     in_ch,
  bptb_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [bptb_pkg::EPS_W-1:0]  cfg_wdata
);
  import bptb_pkg::*;

  // ---------------------------------------------------------------- state
  state_t         state_r;
  op_t            op_r;
  logic           start_r;
  logic           axis_r;        // 0 x, 1 y
  logic           two_r;         // cubic with two quadratic roots
  logic           root_sel_r;    // which of the two roots
  logic [EPS_W-1:0] eps_r;

  coord_t         cur_x_r, cur_y_r;
  coord_t         min_x_r, min_y_r, max_x_r, max_y_r;
  coord_t         px_r [4];
  coord_t         py_r [4];
  coord_t         w_r  [4];      // de casteljau shift line

  coef_t          ca_r, cb_r, cc_r;
  scoef_t         sa_r, sb_r, sc_r;
  logic [63:0]    sq_r;
  logic [31:0]    r_r;
  rnum_t          num_r, den_r;
  logic [DW-1:0]  div_n_r, div_d_r;
  logic           div_go_r, sqrt_go_r;
  logic [SQ_W-1:0] disc_r;
  tpar_t          t_r;
  logic [3:0]     step_r;
  logic           dneg_r;

  logic           out_valid_r;
  coord_t         o_min_x_r, o_min_y_r, o_max_x_r, o_max_y_r;

  // ---------------------------------------------------------------- shared units
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [MA_W+MB_W-1:0] mul_p;
  logic                 div_busy, div_done;
  logic [DW-1:0]        div_q;
  logic                 sqrt_busy, sqrt_done;
  logic [SQ_W/2-1:0]    sqrt_root;

  bptb_mul #(.AW(MA_W), .BW(MB_W)) u_mul (
    .clk (clk), .a (mul_a), .b (mul_b), .p (mul_p)
  );

  bptb_div #(.W(DW)) u_div (
    .clk (clk), .rst_n (rst_n), .start (div_go_r), .num (div_n_r), .den (div_d_r),
    .busy (div_busy), .done (div_done), .quo (div_q)
  );

  bptb_sqrt #(.W(SQ_W)) u_sqrt (
    .clk (clk), .rst_n (rst_n), .start (sqrt_go_r), .din (disc_r),
    .busy (sqrt_busy), .done (sqrt_done), .root (sqrt_root)
  );

  // ---------------------------------------------------------------- helpers
  function automatic logic [CF_W-1:0] mag_cf(input coef_t x);
    mag_cf = x[CF_W-1] ? CF_W'(-x) : CF_W'(x);
  endfunction

  function automatic logic [RN_W-1:0] mag_rn(input rnum_t x);
    mag_rn = x[RN_W-1] ? RN_W'(-x) : RN_W'(x);
  endfunction

  function automatic logic [SC_W-1:0] mag_sc(input scoef_t x);
    mag_sc = x[SC_W-1] ? SC_W'(-x) : SC_W'(x);
  endfunction

  function automatic scoef_t scale_cf(input coef_t x, input logic [2:0] s);
    logic [CF_W-1:0] m;
    logic [SC_W-1:0] ms;
    m  = mag_cf(x) >> s;
    ms = m[SC_W-1:0];
    scale_cf = x[CF_W-1] ? scoef_t'(-$signed(ms)) : $signed(ms);
  endfunction

  // ---------------------------------------------------------------- request side
  logic   accept;
  coord_t cur_bx, cur_by;
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cur_bx      = in_ch.start_path ? '0 : cur_x_r;
  assign cur_by      = in_ch.start_path ? '0 : cur_y_r;

  // ---------------------------------------------------------------- end points
  coord_t bmin_x, bmin_y, bmax_x, bmax_y;
  coord_t ex, ey, sx, sy;
  always_comb begin
    bmin_x = start_r ? CMAX : min_x_r;
    bmin_y = start_r ? CMAX : min_y_r;
    bmax_x = start_r ? CMIN : max_x_r;
    bmax_y = start_r ? CMIN : max_y_r;
    case (op_r)
      OP_MOVE, OP_LINE: begin ex = px_r[1]; ey = py_r[1]; end
      OP_QUAD:          begin ex = px_r[2]; ey = py_r[2]; end
      default:          begin ex = px_r[3]; ey = py_r[3]; end
    endcase
    // a move has no start point on the path
    sx = (op_r == OP_MOVE) ? px_r[1] : px_r[0];
    sy = (op_r == OP_MOVE) ? py_r[1] : py_r[0];
  end

  // ---------------------------------------------------------------- coefficients
  coord_t pv [4];
  coef_t  e0, e1, e2, e3, d2;
  always_comb begin
    for (int i = 0; i < 4; i++) pv[i] = axis_r ? py_r[i] : px_r[i];
    e0 = CF_W'(pv[0]);
    e1 = CF_W'(pv[1]);
    e2 = CF_W'(pv[2]);
    e3 = CF_W'(pv[3]);
    d2 = e0 - (e1 <<< 1) + e2;
  end

  // ---------------------------------------------------------------- root checks
  logic [CF_W-1:0] ma, mb, mc, mx;
  logic [CF_W-1:0] eps_x;
  logic            q_ok;
  logic [2:0]      q_s, c_s;
  scoef_t          sa_c, sb_c, sc_c;
  logic            lin, lin_ok;
  always_comb begin
    ma    = mag_cf(ca_r);
    mb    = mag_cf(cb_r);
    mc    = mag_cf(cc_r);
    eps_x = CF_W'(eps_r);
    // quadratic: cb holds den, cc holds num
    q_ok  = (mb > eps_x) && (cc_r != '0) && (cc_r[CF_W-1] == cb_r[CF_W-1]) && (mc < mb);
    q_s   = 3'd4;
    for (int i = 4; i >= 0; i--) begin
      if ((mb >> i) < (CF_W'(1) << 31)) q_s = 3'(i);
    end
    // cubic: common shift bringing every magnitude below 2^30
    mx = (ma > mb) ? ma : mb;
    if (mc > mx) mx = mc;
    c_s = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if ((mx >> i) < (CF_W'(1) << 30)) c_s = 3'(i);
    end
    sa_c   = scale_cf(ca_r, c_s);
    sb_c   = scale_cf(cb_r, c_s);
    sc_c   = scale_cf(cc_r, c_s);
    lin    = (ma <= eps_x) || (sa_c == '0);
    lin_ok = (mb > eps_x) && (sb_c != '0);
  end

  // discriminant from the squared b term and the a*c product
  logic [65:0] q4;
  logic [66:0] disc;
  logic        ac_neg;
  always_comb begin
    q4     = {mul_p, 2'b00};
    ac_neg = (sa_r[SC_W-1] ^ sc_r[SC_W-1]);
    disc   = ac_neg ? ({3'b000, sq_r} + {1'b0, q4}) : ({3'b000, sq_r} - {1'b0, q4});
  end

  rnum_t           rn_plus, rn_minus, rden;
  logic [RN_W-1:0] mnum, mden;
  logic            r_ok;
  always_comb begin
    rn_plus  = -RN_W'(sb_r) + $signed({2'b00, r_r});
    rn_minus = -RN_W'(sb_r) - $signed({2'b00, r_r});
    rden     = RN_W'(sa_r) <<< 1;
    mnum     = mag_rn(num_r);
    mden     = mag_rn(den_r);
    r_ok     = (num_r != '0) && (den_r != '0) &&
               (num_r[RN_W-1] == den_r[RN_W-1]) && (mnum < mden);
  end

  // ---------------------------------------------------------------- lerp path
  logic [8:0]       scr;
  logic [3:0]       scr_len;
  logic signed [CB:0] ldiff;
  logic [CB:0]      ldmag;
  logic [MA_W-1:0]  lsh;
  logic signed [MA_W+1:0] lsum;
  coord_t           lres;
  always_comb begin
    scr     = (op_r == OP_QUAD) ? SCR_QUAD : SCR_CUBIC;
    scr_len = (op_r == OP_QUAD) ? LEN_QUAD : LEN_CUBIC;
    ldiff   = (CB+1)'(w_r[1]) - (CB+1)'(w_r[0]);
    ldmag   = ldiff[CB] ? (CB+1)'(-ldiff) : (CB+1)'(ldiff);
    lsh     = mul_p[TBITS +: MA_W];
    lsum    = (MA_W+2)'(w_r[0]) + (dneg_r ? -$signed({2'b00, lsh}) : $signed({2'b00, lsh}));
    lres    = lsum[CB-1:0];   // lies between the two end values
  end

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ1: begin
        mul_a = MA_W'(mag_sc(sb_r));
        mul_b = MB_W'(mag_sc(sb_r));
      end
      ST_SQ2: begin
        mul_a = MA_W'(mag_sc(sa_r));
        mul_b = MB_W'(mag_sc(sc_r));
      end
      ST_EVM: begin
        mul_a = MA_W'(ldmag);
        mul_b = t_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  coord_t glo, ghi;
  assign glo = axis_r ? min_y_r : min_x_r;
  assign ghi = axis_r ? max_y_r : max_x_r;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      eps_r       <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      min_x_r     <= CMAX;
      min_y_r     <= CMAX;
      max_x_r     <= CMIN;
      max_y_r     <= CMIN;
      div_go_r    <= 1'b0;
      sqrt_go_r   <= 1'b0;
    end else begin
      div_go_r  <= 1'b0;
      sqrt_go_r <= 1'b0;
      if (cfg_we) eps_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= op_t'(in_ch.op);
            start_r <= in_ch.start_path;
            px_r[0] <= cur_bx;      py_r[0] <= cur_by;
            px_r[1] <= in_ch.pa_x;  py_r[1] <= in_ch.pa_y;
            px_r[2] <= in_ch.pb_x;  py_r[2] <= in_ch.pb_y;
            px_r[3] <= in_ch.pc_x;  py_r[3] <= in_ch.pc_y;
            state_r <= ST_ENDS;
          end
        end

        ST_ENDS: begin
          // end points always enter the box
          min_x_r <= (sx < ex) ? ((sx < bmin_x) ? sx : bmin_x) : ((ex < bmin_x) ? ex : bmin_x);
          max_x_r <= (sx > ex) ? ((sx > bmax_x) ? sx : bmax_x) : ((ex > bmax_x) ? ex : bmax_x);
          min_y_r <= (sy < ey) ? ((sy < bmin_y) ? sy : bmin_y) : ((ey < bmin_y) ? ey : bmin_y);
          max_y_r <= (sy > ey) ? ((sy > bmax_y) ? sy : bmax_y) : ((ey > bmax_y) ? ey : bmax_y);
          cur_x_r <= ex;
          cur_y_r <= ey;
          axis_r  <= 1'b0;
          state_r <= (op_r == OP_QUAD || op_r == OP_CUBIC) ? ST_COEF : ST_DONE;
        end

        ST_COEF: begin
          ca_r       <= -e0 + 3 * e1 - 3 * e2 + e3;
          cb_r       <= (op_r == OP_QUAD) ? d2 : (d2 <<< 1);
          cc_r       <= (op_r == OP_QUAD) ? (e0 - e1) : (e1 - e0);
          root_sel_r <= 1'b0;
          two_r      <= 1'b0;
          state_r    <= ST_CHK;
        end

        ST_CHK: begin
          if (op_r == OP_QUAD) begin
            if (q_ok) begin
              div_n_r  <= DW'(mc >> q_s);
              div_d_r  <= DW'(mb >> q_s);
              div_go_r <= 1'b1;
              state_r  <= ST_DIV;
            end else begin
              state_r  <= ST_GROW;
            end
          end else begin
            sa_r <= sa_c;
            sb_r <= sb_c;
            sc_r <= sc_c;
            if (lin) begin
              // linear derivative: root -c/b
              num_r   <= -RN_W'(sc_c);
              den_r   <= RN_W'(sb_c);
              state_r <= lin_ok ? ST_ROOT : ST_GROW;
            end else begin
              two_r   <= 1'b1;
              state_r <= ST_SQ1;
            end
          end
        end

        ST_SQ1: state_r <= ST_SQ2;

        ST_SQ2: begin
          sq_r    <= mul_p;
          state_r <= ST_DISC;
        end

        ST_DISC: begin
          if (disc[66]) begin
            two_r   <= 1'b0;      // no real root on this axis
            state_r <= ST_GROW;
          end else begin
            disc_r    <= disc[SQ_W-1:0];
            sqrt_go_r <= 1'b1;
            state_r   <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          if (sqrt_done) begin
            r_r     <= sqrt_root;
            state_r <= ST_RSET;
          end
        end

        ST_RSET: begin
          num_r   <= root_sel_r ? rn_minus : rn_plus;
          den_r   <= rden;
          state_r <= ST_ROOT;
        end

        ST_ROOT: begin
          if (r_ok) begin
            div_n_r  <= mnum[DW-1:0];
            div_d_r  <= mden[DW-1:0];
            div_go_r <= 1'b1;
            state_r  <= ST_DIV;
          end else begin
            state_r  <= ST_GROW;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            t_r     <= (div_q > DW'(TMAX)) ? TMAX : div_q[TBITS-1:0];
            for (int i = 0; i < 4; i++) w_r[i] <= pv[i];
            step_r  <= '0;
            state_r <= ST_EVM;
          end
        end

        ST_EVM: begin
          if (scr[step_r]) begin
            dneg_r  <= ldiff[CB];
            state_r <= ST_EVA;
          end else begin
            w_r[0] <= w_r[1];
            w_r[1] <= w_r[2];
            w_r[2] <= w_r[3];
            step_r <= step_r + 1'b1;
          end
        end

        ST_EVA: begin
          w_r[0] <= w_r[1];
          w_r[1] <= w_r[2];
          w_r[2] <= w_r[3];
          w_r[3] <= lres;
          step_r <= step_r + 1'b1;
          if (step_r == scr_len - 1'b1) begin
            // curve value at the root is ready, fold it into the box
            if (axis_r) begin
              if (lres < glo) min_y_r <= lres;
              if (lres > ghi) max_y_r <= lres;
            end else begin
              if (lres < glo) min_x_r <= lres;
              if (lres > ghi) max_x_r <= lres;
            end
            state_r <= ST_GROW;
          end else begin
            state_r <= ST_EVM;
          end
        end

        ST_GROW: begin
          // entered after an evaluation, when a root is rejected or when no real root exists
          if (two_r && !root_sel_r) begin
            root_sel_r <= 1'b1;
            state_r    <= ST_RSET;
          end else if (!axis_r) begin
            axis_r     <= 1'b1;
            state_r    <= ST_COEF;
          end else begin
            state_r    <= ST_DONE;
          end
        end

        ST_DONE: begin
          o_min_x_r   <= min_x_r;
          o_min_y_r   <= min_y_r;
          o_max_x_r   <= max_x_r;
          o_max_y_r   <= max_y_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.box_min_x = o_min_x_r;
  assign out_ch.box_min_y = o_min_y_r;
  assign out_ch.box_max_x = o_max_x_r;
  assign out_ch.box_max_y = o_max_y_r;

  // ---------------------------------------------------------------- checks
  ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE)
    else $error("request taken outside idle");

  ap_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy && sqrt_busy))
    else $error("divider and square root busy together");

  ap_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("quotient arrived while not waiting");

  ap_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.box_min_x <= out_ch.box_max_x) &&
                     (out_ch.box_min_y <= out_ch.box_max_y))
    else $error("result box inverted");

endmodule

>>> test/tb_bezier_path_tight_bounds_unit.sv
// testbench for the bezier path bounding box unit: scoreboard, drivers and checks
`timescale 1ns / 1ps

import bptb_pkg::*;

typedef struct {
  op_t    op;
  logic   start_path;
  coord_t ax, ay, bx, by, cx, cy;
} verb_req_t;

typedef struct {
  coord_t min_x, min_y, max_x, max_y;
} box_t;

// tracks the path state and predicts the running box for every request
class box_scoreboard;
  localparam longint unsigned T_ONE = 64'd1 << TBITS;

  longint unsigned eps;
  longint pos_x, pos_y;
  longint lo_x, lo_y, hi_x, hi_y;
  box_t   expected_boxes[$];
  int     errors;

  function void clear_path();
    lo_x = CMAX; lo_y = CMAX;
    hi_x = CMIN; hi_y = CMIN;
    pos_x = 0; pos_y = 0;
  endfunction

  function void reset_all();
    eps = 0;
    errors = 0;
    expected_boxes.delete();
    clear_path();
  endfunction

  function longint unsigned magn(longint x);
    return (x < 0) ? 64'd0 - longint'(x) : x;
  endfunction

  function longint signed_of(bit neg, longint unsigned m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // (q-p)*t / 2^TBITS truncated toward zero, added to p
  function longint interp(longint p, longint q, longint unsigned t);
    longint d;
    longint unsigned m, r;
    d = q - p;
    m = magn(d);
    r = (m >> TBITS) * t + (((m & (T_ONE - 1)) * t) >> TBITS);
    return p + signed_of(d < 0, r);
  endfunction

  function void widen(ref longint lo, ref longint hi, input longint v);
    if (v < lo) lo = v;
    if (v > hi) hi = v;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else
        res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  function void quad_extreme(longint p0, longint p1, longint p2, ref longint lo,
                             ref longint hi);
    longint den, num;
    longint unsigned un, ud, t;
    den = p0 - 2 * p1 + p2;
    num = p0 - p1;
    if (magn(den) <= eps || num == 0 || ((num < 0) != (den < 0))) return;
    un = magn(num);
    ud = magn(den);
    if (un >= ud) return;
    while (ud >= (64'd1 << 31)) begin
      un >>= 1;
      ud >>= 1;
    end
    t = (un << TBITS) / ud;
    if (t >= T_ONE) t = T_ONE - 1;
    widen(lo, hi, interp(interp(p0, p1, t), interp(p1, p2, t), t));
  endfunction

  function void cubic_extreme(longint p[4], longint num, longint den, ref longint lo,
                              ref longint hi);
    longint unsigned t;
    longint a, b;
    if (num == 0 || den == 0 || ((num < 0) != (den < 0))) return;
    if (magn(num) >= magn(den)) return;
    t = (magn(num) << TBITS) / magn(den);
    a = interp(interp(p[0], p[1], t), interp(p[1], p[2], t), t);
    b = interp(interp(p[1], p[2], t), interp(p[2], p[3], t), t);
    widen(lo, hi, interp(a, b, t));
  endfunction

  function longint shr_mag(longint x, int s);
    return signed_of(x < 0, magn(x) >> s);
  endfunction

  function void cubic_axis(longint p[4], ref longint lo, ref longint hi);
    longint a, b, c, sa, sb, sc, disc;
    longint unsigned m, r;
    int s;
    a = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
    b = 2 * (p[0] - 2 * p[1] + p[2]);
    c = p[1] - p[0];
    m = magn(a);
    if (magn(b) > m) m = magn(b);
    if (magn(c) > m) m = magn(c);
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    sa = shr_mag(a, s);
    sb = shr_mag(b, s);
    sc = shr_mag(c, s);
    // degenerate leading term: derivative is linear
    if (magn(a) <= eps || sa == 0) begin
      if (magn(b) > eps && sb != 0) cubic_extreme(p, -sc, sb, lo, hi);
      return;
    end
    disc = sb * sb - 4 * sa * sc;
    if (disc < 0) return;
    r = int_sqrt(disc);
    cubic_extreme(p, -sb + longint'(r), 2 * sa, lo, hi);
    cubic_extreme(p, -sb - longint'(r), 2 * sa, lo, hi);
  endfunction

  function void note_request(verb_req_t rq);
    longint px[4], py[4];
    box_t b;
    if (rq.start_path) clear_path();
    case (rq.op)
      OP_MOVE: begin
        pos_x = rq.ax; pos_y = rq.ay;
        widen(lo_x, hi_x, rq.ax);
        widen(lo_y, hi_y, rq.ay);
      end
      OP_LINE: begin
        widen(lo_x, hi_x, pos_x); widen(lo_x, hi_x, rq.ax);
        widen(lo_y, hi_y, pos_y); widen(lo_y, hi_y, rq.ay);
        pos_x = rq.ax; pos_y = rq.ay;
      end
      OP_QUAD: begin
        widen(lo_x, hi_x, pos_x); widen(lo_x, hi_x, rq.bx);
        widen(lo_y, hi_y, pos_y); widen(lo_y, hi_y, rq.by);
        quad_extreme(pos_x, rq.ax, rq.bx, lo_x, hi_x);
        quad_extreme(pos_y, rq.ay, rq.by, lo_y, hi_y);
        pos_x = rq.bx; pos_y = rq.by;
      end
      default: begin
        widen(lo_x, hi_x, pos_x); widen(lo_x, hi_x, rq.cx);
        widen(lo_y, hi_y, pos_y); widen(lo_y, hi_y, rq.cy);
        px = '{pos_x, rq.ax, rq.bx, rq.cx};
        py = '{pos_y, rq.ay, rq.by, rq.cy};
        cubic_axis(px, lo_x, hi_x);
        cubic_axis(py, lo_y, hi_y);
        pos_x = rq.cx; pos_y = rq.cy;
      end
    endcase
    b.min_x = coord_t'(lo_x);
    b.min_y = coord_t'(lo_y);
    b.max_x = coord_t'(hi_x);
    b.max_y = coord_t'(hi_y);
    expected_boxes.push_back(b);
  endfunction

  function void check_result(box_t act);
    box_t e;
    if (expected_boxes.size() == 0) begin
      $display("%0t: unexpected box %0d %0d %0d %0d", $time, act.min_x, act.min_y,
               act.max_x, act.max_y);
      errors++;
      return;
    end
    e = expected_boxes.pop_front();
    if (act.min_x !== e.min_x) begin
      $display("%0t: min_x expected %0d actual %0d", $time, e.min_x, act.min_x);
      errors++;
    end
    if (act.min_y !== e.min_y) begin
      $display("%0t: min_y expected %0d actual %0d", $time, e.min_y, act.min_y);
      errors++;
    end
    if (act.max_x !== e.max_x) begin
      $display("%0t: max_x expected %0d actual %0d", $time, e.max_x, act.max_x);
      errors++;
    end
    if (act.max_y !== e.max_y) begin
      $display("%0t: max_y expected %0d actual %0d", $time, e.max_y, act.max_y);
      errors++;
    end
  endfunction
endclass

module tb_bezier_path_tight_bounds_unit;
  localparam int STALL_LIMIT = 20000;  // cycles without any handshake

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [EPS_W-1:0] cfg_wdata = '0;
  logic no_idle = 1'b0;   // long stretch with both sides always ready
  int   stall_cycles = 0;

  bptb_in_if  in_ch();
  bptb_out_if out_ch();
  box_scoreboard boxes = new();

  bezier_path_tight_bounds_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.start_path = 1'b0;
    in_ch.pa_x = '0; in_ch.pa_y = '0;
    in_ch.pb_x = '0; in_ch.pb_y = '0;
    in_ch.pc_x = '0; in_ch.pc_y = '0;
    out_ch.ready = 1'b0;
  end

  // result side backpressure, about 6 stalls in a hundred
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 6);
  end

  // request monitor: every accepted request feeds the predictor
  always @(posedge clk) begin
    verb_req_t rq;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rq.op = op_t'(in_ch.op);
      rq.start_path = in_ch.start_path;
      rq.ax = in_ch.pa_x; rq.ay = in_ch.pa_y;
      rq.bx = in_ch.pb_x; rq.by = in_ch.pb_y;
      rq.cx = in_ch.pc_x; rq.cy = in_ch.pc_y;
      boxes.note_request(rq);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    box_t act;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act.min_x = out_ch.box_min_x;
      act.min_y = out_ch.box_min_y;
      act.max_x = out_ch.box_max_x;
      act.max_y = out_ch.box_max_y;
      boxes.check_result(act);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hold the request until it is taken; random idle gaps in between
  task automatic send_verb(op_t op, logic sp, coord_t ax, coord_t ay, coord_t bx = 0,
                           coord_t by = 0, coord_t cx = 0, coord_t cy = 0);
    if (!no_idle && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.start_path <= sp;
    in_ch.pa_x <= ax; in_ch.pa_y <= ay;
    in_ch.pb_x <= bx; in_ch.pb_y <= by;
    in_ch.pc_x <= cx; in_ch.pc_y <= cy;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  // epsilon only changes while nothing is in flight
  task automatic write_epsilon(logic [EPS_W-1:0] v);
    in_ch.valid <= 1'b0;
    wait (boxes.expected_boxes.size() == 0);
    repeat (350) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    boxes.eps = v;
  endtask

  // mostly small coordinates so curves have interior extrema, sometimes full range
  function automatic coord_t rand_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return coord_t'($signed($urandom_range(0, 2097152)) - 1048576);
    if (sel < 90) return coord_t'($urandom);
    if (sel < 95) return CMAX;
    return CMIN;
  endfunction

  task automatic random_paths(int count);
    op_t op;
    for (int i = 0; i < count; i++) begin
      // mostly a move to open the path, then a run of segments
      if (i % 12 == 0 || $urandom_range(99) < 3)
        op = ($urandom_range(99) < 85) ? OP_MOVE : op_t'($urandom_range(3));
      else
        op = op_t'($urandom_range(1, 3));
      send_verb(op, (i % 12 == 0) ? 1'b1 : ($urandom_range(99) < 4), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    boxes.reset_all();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each verb, roots inside and outside the unit interval
    send_verb(OP_LINE, 1'b0, CMAX, CMIN);
    send_verb(OP_MOVE, 1'b1, CMIN, CMAX);
    send_verb(OP_LINE, 1'b0, CMAX, CMIN);
    send_verb(OP_MOVE, 1'b1, 0, 0);
    send_verb(OP_QUAD, 1'b0, 32'sd100000, 32'sd200000, 32'sd0, 32'sd65536);
    send_verb(OP_QUAD, 1'b0, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
    send_verb(OP_QUAD, 1'b0, CMAX, CMIN, CMIN, CMAX);
    send_verb(OP_MOVE, 1'b1, 0, 0);
    send_verb(OP_CUBIC, 1'b0, 32'sd300000, -32'sd300000, -32'sd300000, 32'sd300000,
              32'sd10000, 32'sd5000);
    send_verb(OP_CUBIC, 1'b0, 32'sd3000, 32'sd3000, 32'sd1000, 32'sd1000, -32'sd6000,
              -32'sd6000);
    send_verb(OP_CUBIC, 1'b0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6);
    send_verb(OP_CUBIC, 1'b0, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    send_verb(OP_CUBIC, 1'b1, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX);
    send_verb(OP_QUAD, 1'b0, CMAX, CMAX, CMIN, CMIN);
    send_verb(OP_LINE, 1'b0, -32'sd1, -32'sd1);

    // tiny curvature is treated as flat once epsilon is large
    write_epsilon(16'hFFFF);
    send_verb(OP_MOVE, 1'b1, 0, 0);
    send_verb(OP_QUAD, 1'b0, 32'sd30000, 32'sd20000, 32'sd0, 32'sd0);
    send_verb(OP_CUBIC, 1'b0, 32'sd3000, 32'sd3000, 32'sd1000, 32'sd1000, -32'sd6000,
              -32'sd6000);
    send_verb(OP_CUBIC, 1'b0, 32'sd300000, -32'sd300000, -32'sd300000, 32'sd300000,
              32'sd10000, 32'sd5000);
    random_paths(350);

    write_epsilon(16'd0);
    no_idle <= 1'b1;
    random_paths(300);
    no_idle <= 1'b0;
    random_paths(50);

    write_epsilon(16'($urandom_range(1, 2000)));
    random_paths(300);

    write_epsilon(16'($urandom));
    random_paths(330);

    in_ch.valid <= 1'b0;
    wait (boxes.expected_boxes.size() == 0);
    repeat (400) @(posedge clk);
    if (boxes.errors == 0 && boxes.expected_boxes.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
